/* hw/rtl/tct_pkg.sv */
package tct_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam logic [2:0] OP_FIND   = 3'd0;
	localparam logic [2:0] OP_INSERT = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_QUERY  = 3'd3;
	localparam logic [2:0] OP_ALLOC  = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_EXISTS    = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_NO_PORT   = 3'd4;

	localparam logic [1:0] FAM_IPV4 = 2'd1;
	localparam logic [1:0] FAM_IPV6 = 2'd2;

	localparam logic [15:0] EPH_FIRST_RST = 16'd49152;
	localparam logic [15:0] EPH_LAST_RST  = 16'd65535;

	localparam logic REG_EPH_FIRST = 1'b0;
	localparam logic REG_EPH_LAST  = 1'b1;

	typedef struct packed {
		logic [2:0]  operation;
		logic [1:0]  local_family;
		logic [63:0] local_addr_hi;
		logic [63:0] local_addr_lo;
		logic [15:0] lport;
		logic [1:0]  peer_family;
		logic [63:0] peer_addr_hi;
		logic [63:0] peer_addr_lo;
		logic [15:0] rport;
		logic [7:0]  conn_handle;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  found_handle;
		logic        port_busy;
		logic [15:0] allocated_port;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic scan_init;
		logic scan_step;
	} cmd_t;

	typedef struct packed {
		logic op_alloc;
		logic range_ok;
		logic scan_done;
	} sts_t;

endpackage

/* hw/rtl/tct_ctrl.sv */
module tct_ctrl import tct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_SCAN = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   out_free;
	logic   rsp_set;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		rsp_set = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.op_alloc && sts.range_ok) begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end else if (out_free) begin
					cmd.exec = 1'b1;
					rsp_set  = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_SCAN: begin
				// hold the final candidate until the output register frees up
				if (!sts.scan_done) begin
					cmd.scan_step = 1'b1;
				end else if (out_free) begin
					cmd.scan_step = 1'b1;
					rsp_set       = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_set) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/tct_dpath.sv */
module tct_dpath import tct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  req_t        req,
	input  logic [15:0] eph_first,
	input  logic [15:0] eph_last,
	input  cmd_t        cmd,
	output sts_t        sts,
	output rsp_t        rsp
);

	function automatic logic addr_match(input logic [1:0] fa, input logic [63:0] ahi,
			input logic [63:0] alo, input logic [1:0] fb, input logic [63:0] bhi,
			input logic [63:0] blo);
		logic m;
		if (fa != fb) begin
			m = 1'b0;
		end else if (fa == FAM_IPV4) begin
			m = (alo[31:0] == blo[31:0]);
		end else if (fa == FAM_IPV6) begin
			m = (ahi == bhi) && (alo == blo);
		end else begin
			m = 1'b1;
		end
		return m;
	endfunction

	req_t        req_q;
	rsp_t        rsp_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [7:0]  handle_q [TABLE_DEPTH];
	logic [3:0]  fam_q    [TABLE_DEPTH];
	logic [31:0] ports_q  [TABLE_DEPTH];
	logic [63:0] laddr_lo_q [TABLE_DEPTH];
	logic [63:0] laddr_hi_q [TABLE_DEPTH];
	logic [63:0] paddr_lo_q [TABLE_DEPTH];
	logic [63:0] paddr_hi_q [TABLE_DEPTH];
	logic [15:0] next_eph_q, cand_q, start_q, remain_q;

	logic [15:0] port_sel;
	logic [TABLE_DEPTH-1:0] peer_hit, full_hit, hdl_hit;
	logic [IDX_W-1:0] full_idx, hdl_idx, free_idx;
	logic any_peer, any_full, any_hdl, any_free;
	logic [15:0] start_d, cand_next;
	logic        cand_free;
	rsp_t        exec_rsp;
	rsp_t        scan_rsp;
	logic        do_insert, do_remove;

	assign port_sel = (req_q.operation == OP_ALLOC) ? cand_q : req_q.lport;

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			peer_hit[i] = valid_q[i] && (ports_q[i][15:0] == port_sel)
				&& (ports_q[i][31:16] == req_q.rport)
				&& addr_match(fam_q[i][3:2], paddr_hi_q[i], paddr_lo_q[i],
					req_q.peer_family, req_q.peer_addr_hi, req_q.peer_addr_lo);
			full_hit[i] = peer_hit[i] && addr_match(fam_q[i][1:0], laddr_hi_q[i],
				laddr_lo_q[i], req_q.local_family, req_q.local_addr_hi,
				req_q.local_addr_lo);
			hdl_hit[i] = valid_q[i] && (handle_q[i] == req_q.conn_handle);
		end
	end

	// lowest index wins: walk down so the last assignment is the smallest
	always_comb begin
		full_idx = '0;
		hdl_idx  = '0;
		free_idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (full_hit[i]) full_idx = IDX_W'(i);
			if (hdl_hit[i])  hdl_idx  = IDX_W'(i);
			if (!valid_q[i]) free_idx = IDX_W'(i);
		end
	end

	assign any_peer = |peer_hit;
	assign any_full = |full_hit;
	assign any_hdl  = |hdl_hit;
	assign any_free = !(&valid_q);

	assign start_d   = (next_eph_q < eph_first || next_eph_q > eph_last) ? eph_first
		: next_eph_q;
	assign cand_next = (cand_q == eph_last) ? eph_first : cand_q + 16'd1;
	assign cand_free = !any_peer;

	assign sts.op_alloc  = (req_q.operation == OP_ALLOC);
	assign sts.range_ok  = (eph_last >= eph_first);
	assign sts.scan_done = cand_free || (remain_q == 16'd0);

	always_comb begin
		exec_rsp  = '0;
		do_insert = 1'b0;
		do_remove = 1'b0;
		case (req_q.operation)
			OP_FIND: begin
				if (any_full) begin
					exec_rsp.found_handle = handle_q[full_idx];
				end else begin
					exec_rsp.status = ST_NOT_FOUND;
				end
			end
			OP_INSERT: begin
				if (any_full) begin
					exec_rsp.status = ST_EXISTS;
				end else if (!any_free) begin
					exec_rsp.status = ST_FULL;
				end else begin
					do_insert = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (any_hdl) begin
					do_remove = 1'b1;
				end else begin
					exec_rsp.status = ST_NOT_FOUND;
				end
			end
			OP_QUERY: exec_rsp.port_busy = any_peer;
			OP_ALLOC: exec_rsp.status = ST_NO_PORT;
			default:  exec_rsp.status = ST_NOT_FOUND;
		endcase
	end

	always_comb begin
		scan_rsp = '0;
		if (cand_free) begin
			scan_rsp.allocated_port = cand_q;
		end else begin
			scan_rsp.status = ST_NO_PORT;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.exec) begin
			rsp_q <= exec_rsp;
		end else if (cmd.scan_step && sts.scan_done) begin
			rsp_q <= scan_rsp;
		end
		if (cmd.scan_init) begin
			cand_q   <= start_d;
			start_q  <= start_d;
			remain_q <= eph_last - eph_first;
		end else if (cmd.scan_step) begin
			cand_q   <= cand_next;
			remain_q <= remain_q - 16'd1;
		end
		if (cmd.exec && do_insert) begin
			handle_q[free_idx]   <= req_q.conn_handle;
			fam_q[free_idx]      <= {req_q.peer_family, req_q.local_family};
			ports_q[free_idx]    <= {req_q.rport, req_q.lport};
			laddr_lo_q[free_idx] <= req_q.local_addr_lo;
			laddr_hi_q[free_idx] <= req_q.local_addr_hi;
			paddr_lo_q[free_idx] <= req_q.peer_addr_lo;
			paddr_hi_q[free_idx] <= req_q.peer_addr_hi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			next_eph_q <= EPH_FIRST_RST;
		end else begin
			if (cmd.exec && do_insert) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (cmd.exec && do_remove) begin
				valid_q[hdl_idx] <= 1'b0;
			end
			// a failed scan returns the pointer to where it started
			if (cmd.scan_step && sts.scan_done) begin
				next_eph_q <= cand_free ? cand_next : start_q;
			end
		end
	end

	assign rsp = rsp_q;

endmodule

/* hw/rtl/tcp_connection_table.sv */
// TCP four-tuple connection table.
// Request channel (req_valid/req_ready, payload req) carries one operation:
// find, insert, remove, port-in-use query or ephemeral port allocation.
// Response channel (rsp_valid/rsp_ready, payload rsp) returns one item per
// request, in order.
// Find, insert, remove and query capture the item in the request register,
// then match it against all 16 entries in parallel and load the result.
// Allocation tries candidate ports one per cycle through the shared match
// unit (at most the range size), holding the final one while output is busy.
// The result sits in an output register; the next item is taken only after the
// previous one has been written there. If the receiver stalls, the last
// result holds and at most one further item is accepted and waits for the
// output register before finishing.
// Reset empties the table, sets the ephemeral range to 49152..65535 and points
// the allocator at its first port. The user must write the APB range registers
// (offset 0 first, 4 last port) only while idle; the block does not enforce it.
module tcp_connection_table import tct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] eph_first_q, eph_last_q;
	logic        reg_wr;
	cmd_t        cmd;
	sts_t        sts;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_EPH_LAST) ? {16'd0, eph_last_q} : {16'd0, eph_first_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eph_first_q <= EPH_FIRST_RST;
			eph_last_q  <= EPH_LAST_RST;
		end else if (reg_wr) begin
			if (paddr[2] == REG_EPH_LAST) begin
				eph_last_q <= pwdata[15:0];
			end else begin
				eph_first_q <= pwdata[15:0];
			end
		end
	end

	tct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tct_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.eph_first (eph_first_q),
		.eph_last  (eph_last_q),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item accepted while previous one still in work");

	a_port_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.allocated_port != 16'd0 |-> rsp.status == ST_OK)
		else $error("allocated port reported with failing status");

	a_handle_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found_handle != 8'd0 |-> rsp.status == ST_OK)
		else $error("handle reported with failing status");

endmodule
